// File: hdl/poly_pkg.sv
// shared types, codes and the word saturation helper for the polynomial evaluator
// no dependencies

package poly_pkg;

	localparam int WORD_W  = 32;
	localparam int PROD_W  = 2 * WORD_W;
	localparam int FUNC_W  = 2;
	localparam int INDEX_W = 4;
	localparam int FORM_W  = 2;
	localparam int ORDER_W = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W   = 4;
	localparam int INDEX_MAX = (1 << INDEX_W) - 1;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [FUNC_W-1:0]        func_t;
	typedef logic [INDEX_W-1:0]       index_t;
	typedef logic [FORM_W-1:0]        form_t;
	typedef logic [ORDER_W-1:0]       order_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
	typedef logic [CFG_W-1:0]         cfg_data_t;

	localparam func_t FUNC_COEF = 2'd0;
	localparam func_t FUNC_NODE = 2'd1;
	localparam func_t FUNC_EVAL = 2'd2;

	localparam form_t FORM_POWER  = 2'd0;
	localparam form_t FORM_HORNER = 2'd1;
	localparam form_t FORM_NEWTON = 2'd2;

	localparam cfg_idx_t CFG_FORM  = 1'b0;
	localparam cfg_idx_t CFG_ORDER = 1'b1;

	localparam prod_t WORD_MAX = 64'sd2147483647;
	localparam prod_t WORD_MIN = -64'sd2147483648;

	typedef struct packed {
		logic  start;
		logic  write;
		logic  mul;
		logic  acc;
		logic  publish;
	} dp_cmd_t;

	typedef struct packed {
		logic  empty;
		logic  last;
		logic  out_free;
	} dp_stat_t;

	typedef struct packed {
		logic  ovf;
		word_t val;
	} sat_t;

	function automatic sat_t sat_word(input prod_t v);
		sat_t r;
		if (v > WORD_MAX) begin
			r.ovf = 1'b1;
			r.val = WORD_MAX[WORD_W-1:0];
		end else if (v < WORD_MIN) begin
			r.ovf = 1'b1;
			r.val = WORD_MIN[WORD_W-1:0];
		end else begin
			r.ovf = 1'b0;
			r.val = v[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: hdl/poly_in_if.sv
// input word channel: func, index and value with valid/ready
// depends on poly_pkg

interface poly_in_if;
	logic               valid;
	logic               ready;
	poly_pkg::func_t    func;
	poly_pkg::index_t   index;
	poly_pkg::word_t    value;

	modport source (output valid, output func, output index, output value, input ready);
	modport sink (input valid, input func, input index, input value, output ready);
endinterface

// File: hdl/poly_out_if.sv
// result word channel: result and overflow with valid/ready
// depends on poly_pkg

interface poly_out_if;
	logic               valid;
	logic               ready;
	poly_pkg::word_t    result;
	logic               overflow;

	modport source (output valid, output result, output overflow, input ready);
	modport sink (input valid, input result, input overflow, output ready);
endinterface

// File: hdl/polynomial_evaluator.sv
// Polynomial evaluator, signed Q16.16. A write word (coefficient or node) is
// stored when it is accepted. An evaluate word runs the loop, with a pass per
// coefficient in power series and Newton form and per coefficient below the top
// in Horner form, and skips the loop for an unused form code. Each pass has a
// multiply step on the two multipliers, then a saturating shift and accumulate
// step. The block takes no new word while an evaluation runs; a finished result
// sits in the output register and the next word is accepted while it waits, the
// loop only stalls at its end when the previous result is still not taken.
// depends on poly_pkg, poly_in_if, poly_out_if, poly_ctrl, poly_dp

module polynomial_evaluator #(
	parameter int MAX_ORDER = 15,
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	poly_in_if.sink             din,
	poly_out_if.source          dout,
	input  logic                cfg_we,
	input  poly_pkg::cfg_idx_t  cfg_index,
	input  poly_pkg::cfg_data_t cfg_data
);
	import poly_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_eval;

	assign in_eval = (din.func == FUNC_EVAL);

	poly_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_eval  (in_eval),
		.in_ready (din.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	poly_dp #(
		.MAX_ORDER (MAX_ORDER),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.func      (din.func),
		.index     (din.index),
		.value     (din.value),
		.result    (dout.result),
		.overflow  (dout.overflow),
		.out_valid (dout.valid),
		.out_ready (dout.ready)
	);

endmodule

// File: hdl/poly_ctrl.sv
// sequencer for the evaluator: accept, multiply / accumulate loop, publish
// depends on poly_pkg

module poly_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_eval,
	output logic               in_ready,
	output poly_pkg::dp_cmd_t  cmd,
	input  poly_pkg::dp_stat_t stat
);
	import poly_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_ACC  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_eval) begin
						cmd.start = 1'b1;
						state_d   = stat.empty ? ST_FIN : ST_MUL;
					end else begin
						cmd.write = 1'b1;
					end
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = stat.last ? ST_FIN : ST_MUL;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hdl/poly_dp.sv
// datapath: config registers, coefficient and node tables, two multipliers,
// saturating accumulate and the output word register; depends on poly_pkg

module poly_dp #(
	parameter int MAX_ORDER = 15,
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  poly_pkg::dp_cmd_t   cmd,
	output poly_pkg::dp_stat_t  stat,
	input  logic                cfg_we,
	input  poly_pkg::cfg_idx_t  cfg_index,
	input  poly_pkg::cfg_data_t cfg_data,
	input  poly_pkg::func_t     func,
	input  poly_pkg::index_t    index,
	input  poly_pkg::word_t     value,
	output poly_pkg::word_t     result,
	output logic                overflow,
	output logic                out_valid,
	input  logic                out_ready
);
	import poly_pkg::*;

	localparam int TOP   = (MAX_ORDER < INDEX_MAX) ? MAX_ORDER : INDEX_MAX;
	localparam int DEPTH = TOP + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(DEPTH + 1);
	localparam word_t ONE = word_t'(1) <<< FRAC_BITS;

	typedef logic [AW-1:0] addr_t;
	typedef logic [RW-1:0] rem_t;

	form_t  form_q;
	order_t order_q;
	word_t  coef_q [DEPTH];
	word_t  node_q [DEPTH];

	word_t  x_q, term_q, acc_q, d_q;
	logic   d_ovf_q, ovf_q;
	addr_t  idx_q;
	rem_t   rem_q;
	prod_t  pa_s1, pb_s1;

	word_t  result_q;
	logic   overflow_q, out_valid_q;

	order_t n;
	addr_t  n_a, idx_nx;
	word_t  coef_rd, node_nx, mul_a, mul_b, add_b, sat_a_v, sat_b_v;
	logic   horner, newton, more;
	prod_t  sh_a, sh_b, sum;
	sat_t   sat_a, sat_b, sat_sum, d_start, d_next;

	always_comb begin
		n       = (int'(order_q) > TOP) ? order_t'(TOP) : order_q;
		n_a     = n[AW-1:0];
		idx_nx  = idx_q + 1'b1;
		horner  = (form_q == FORM_HORNER);
		newton  = (form_q == FORM_NEWTON);
		more    = (rem_q > rem_t'(1));
		coef_rd = (int'(idx_q) < DEPTH) ? coef_q[idx_q] : '0;
		node_nx = (int'(idx_nx) < DEPTH) ? node_q[idx_nx] : '0;

		mul_a   = horner ? acc_q : term_q;
		mul_b   = horner ? x_q : coef_rd;

		sh_a    = pa_s1 >>> FRAC_BITS;
		sh_b    = pb_s1 >>> FRAC_BITS;
		sat_a   = sat_word(sh_a);
		sat_b   = sat_word(sh_b);
		sat_a_v = sat_a.val;
		sat_b_v = sat_b.val;
		add_b   = horner ? coef_rd : acc_q;
		sum     = prod_t'(sat_a_v) + prod_t'(add_b);
		sat_sum = sat_word(sum);

		d_start = sat_word(prod_t'(value) - prod_t'(node_q[0]));
		d_next  = sat_word(prod_t'(x_q) - prod_t'(node_nx));

		stat.empty    = !(form_q == FORM_POWER || newton) && !(horner && n != '0);
		stat.last     = (rem_q == rem_t'(1));
		stat.out_free = !out_valid_q || out_ready;
	end

	// config and tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			form_q  <= FORM_HORNER;
			order_q <= '0;
			for (int i = 0; i < DEPTH; i++) begin
				coef_q[i] <= '0;
				node_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FORM:  form_q  <= cfg_data[FORM_W-1:0];
					CFG_ORDER: order_q <= cfg_data[ORDER_W-1:0];
					default: ;
				endcase
			end
			if (cmd.write && int'(index) < DEPTH) begin
				if (func == FUNC_COEF) begin
					coef_q[index[AW-1:0]] <= value;
				end else if (func == FUNC_NODE) begin
					node_q[index[AW-1:0]] <= value;
				end
			end
		end
	end

	// evaluation loop
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q     <= value;
			term_q  <= ONE;
			acc_q   <= horner ? coef_q[n_a] : '0;
			idx_q   <= horner ? addr_t'(n_a - 1'b1) : '0;
			rem_q   <= (form_q == FORM_POWER || newton) ? rem_t'(rem_t'(n) + 1'b1)
				: (horner ? rem_t'(n) : '0);
			d_q     <= newton ? d_start.val : value;
			d_ovf_q <= newton ? d_start.ovf : 1'b0;
			ovf_q   <= 1'b0;
		end
		if (cmd.mul) begin
			pa_s1 <= mul_a * mul_b;
			pb_s1 <= term_q * d_q;
		end
		if (cmd.acc) begin
			acc_q <= sat_sum.val;
			if (!horner && more) begin
				term_q <= sat_b_v;
				ovf_q  <= ovf_q | sat_a.ovf | sat_sum.ovf | sat_b.ovf | d_ovf_q;
			end else begin
				ovf_q  <= ovf_q | sat_a.ovf | sat_sum.ovf;
			end
			idx_q   <= horner ? addr_t'(idx_q - 1'b1) : idx_nx;
			d_q     <= newton ? d_next.val : x_q;
			d_ovf_q <= newton ? d_next.ovf : 1'b0;
			rem_q   <= rem_q - 1'b1;
		end
		if (cmd.publish) begin
			result_q   <= acc_q;
			overflow_q <= ovf_q;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result    = result_q;
	assign overflow  = overflow_q;
	assign out_valid = out_valid_q;

endmodule
